>>> rtl/core/ssc_pkg.sv
// Shared types and constants for the shellcode signature scanner.
// No dependencies; every other file of the scanner depends on this package.
`timescale 1ns / 1ps

package ssc_pkg;

  // Byte position and reported offsets
  localparam int unsigned POS_W = 32;

  // Configuration register widths and reset values
  localparam int unsigned NOP_W      = 7;
  localparam int unsigned XMIN_W     = 7;
  localparam int unsigned PMIN_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [NOP_W-1:0]  NOP_RUN_RESET  = 7'd16;
  localparam logic [XMIN_W-1:0] XOR_MIN_RESET  = 7'd39;
  localparam logic [PMIN_W-1:0] PUSH_MIN_RESET = 6'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOP_RUN  = 2'd0,
    CFG_XOR_MIN  = 2'd1,
    CFG_PUSH_MIN = 2'd2
  } cfg_idx_e;

  // XOR window detector
  localparam int unsigned XOR_SCAN_LIMIT = 2097152;
  localparam int unsigned XOR_WINDOW     = 64;
  localparam int unsigned XOR_FILL_W     = $clog2(XOR_WINDOW);
  localparam int unsigned XOR_CNT_W      = $clog2(XOR_WINDOW + 1);
  localparam int unsigned XOR_KEYS       = 256;

  // Stack string detector
  localparam int unsigned PUSH_SPAN  = 32;
  localparam int unsigned PUSH_CNT_W = $clog2(PUSH_SPAN + 1);

  // Sled run counter
  localparam int unsigned RUN_W = 7;

  // Opcode bytes
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_CALL      = 8'hE8;
  localparam logic [7:0] POP_MASK     = 8'hF8;
  localparam logic [7:0] OP_POP_BASE  = 8'h58;
  localparam logic [7:0] FST_B0       = 8'hD9;
  localparam logic [7:0] FST_B1       = 8'hEE;
  localparam logic [7:0] FST_B3       = 8'h74;
  localparam logic [7:0] FST_B4       = 8'h24;
  localparam logic [7:0] FST_B5       = 8'hF4;
  localparam logic [7:0] ROR_B0       = 8'hC1;
  localparam logic [7:0] ROR_B1       = 8'hCF;
  localparam logic [7:0] ROR_B2       = 8'h0D;
  localparam logic [7:0] OP_PUSH      = 8'h68;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7E;

  // Flag plus offset of the first occurrence of a signature
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] off;
  } hit_t;

  // Sequence detector view of the buffer after the current beat
  typedef struct packed {
    logic             sled_found;
    logic [POS_W-1:0] sled_offset;
    logic             getpc_found;
    logic [POS_W-1:0] getpc_offset;
    logic             ror_found;
    logic [POS_W-1:0] ror_offset;
    logic             stack_hit;
  } seq_report_t;

  function automatic logic is_print(input logic [7:0] c);
    return (c >= PRINT_LO) && (c <= PRINT_HI);
  endfunction

endpackage

>>> rtl/core/ssc_if.sv
// Handshake channels of the scanner: byte input, report output, config write.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps

interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ssc_out_if;
  logic                     valid;
  logic                     ready;
  logic                     sled_found;
  logic [ssc_pkg::POS_W-1:0] sled_offset;
  logic                     getpc_found;
  logic [ssc_pkg::POS_W-1:0] getpc_offset;
  logic                     ror_hash_found;
  logic [ssc_pkg::POS_W-1:0] ror_hash_offset;
  logic                     xor_found;
  logic                     stack_found;

  modport source (output valid, output sled_found, output sled_offset,
                  output getpc_found, output getpc_offset, output ror_hash_found,
                  output ror_hash_offset, output xor_found, output stack_found,
                  input ready);
  modport sink   (input valid, input sled_found, input sled_offset,
                  input getpc_found, input getpc_offset, input ror_hash_found,
                  input ror_hash_offset, input xor_found, input stack_found,
                  output ready);
endinterface

interface ssc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssc_pkg::CFG_IDX_W-1:0]  index;
  logic [ssc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/shellcode_signature_scanner.sv
// Shellcode signature scanner, top level.
// Throughput: one byte beat per cycle while the report output is not stalled, with no gaps between buffers.
// The report register is loaded with the last byte of a buffer and is valid in the cycle after it is accepted.
// Every detector updates from the input byte in the same cycle that the beat is accepted.
// Reset (rst_ni, async, active low) clears all scan state and loads config defaults.
`timescale 1ns / 1ps

module shellcode_signature_scanner (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssc_in_if.sink          in_i,
  ssc_out_if.source       out_o,
  ssc_cfg_if.sink         cfg_i
);
  import ssc_pkg::*;

  logic [NOP_W-1:0]  nop_run_q;
  logic [XMIN_W-1:0] xor_min_q;
  logic [PMIN_W-1:0] push_min_q;
  logic [POS_W-1:0]  pos_q;
  logic              beat, last, scan, xor_hit;
  seq_report_t       seq_rep;

  logic              out_valid_q;
  seq_report_t       rep_q;
  logic              xor_q, stack_q;

  // Accept a beat whenever the output register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign beat       = in_i.valid && in_i.ready;
  assign last       = in_i.last_byte;

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nop_run_q  <= NOP_RUN_RESET;
      xor_min_q  <= XOR_MIN_RESET;
      push_min_q <= PUSH_MIN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_NOP_RUN:  nop_run_q  <= NOP_W'(cfg_i.data);
        CFG_XOR_MIN:  xor_min_q  <= XMIN_W'(cfg_i.data);
        CFG_PUSH_MIN: push_min_q <= PMIN_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Byte position, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (beat) begin
      if (last) begin
        pos_q <= '0;
      end else if (pos_q != '1) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // XOR scanning only inside the scan limit
  assign scan = (pos_q < POS_W'(XOR_SCAN_LIMIT)) && (pos_q != '1);

  ssc_xor_lanes u_xor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .scan_i      (scan),
    .clear_i     (last),
    .data_byte_i (in_i.data_byte),
    .xor_min_i   (xor_min_q),
    .xor_hit_o   (xor_hit)
  );

  ssc_seq_detect u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .clear_i     (last),
    .data_byte_i (in_i.data_byte),
    .pos_i       (pos_q),
    .nop_run_i   (nop_run_q),
    .push_min_i  (push_min_q),
    .report_o    (seq_rep)
  );

  // Report register, loaded on the last beat of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat && last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && last) begin
      rep_q   <= seq_rep;
      xor_q   <= xor_hit;
      stack_q <= seq_rep.stack_hit && (pos_q >= POS_W'(PUSH_SPAN - 1));
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sled_found      = rep_q.sled_found;
  assign out_o.sled_offset     = rep_q.sled_offset;
  assign out_o.getpc_found     = rep_q.getpc_found;
  assign out_o.getpc_offset    = rep_q.getpc_offset;
  assign out_o.ror_hash_found  = rep_q.ror_found;
  assign out_o.ror_hash_offset = rep_q.ror_offset;
  assign out_o.xor_found       = xor_q;
  assign out_o.stack_found     = stack_q;

endmodule

>>> rtl/core/ssc_xor_lanes.sv
// XOR window detector: one printable counter per nonzero key, all updated each beat.
// Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_xor_lanes (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      beat_i,
  input  logic                      scan_i,
  input  logic                      clear_i,
  input  logic [7:0]                data_byte_i,
  input  logic [ssc_pkg::XMIN_W-1:0] xor_min_i,
  output logic                      xor_hit_o
);
  import ssc_pkg::*;

  logic [XOR_FILL_W-1:0] fill_q, fill_d;
  logic                  hit_q, hit_d;
  logic                  win_end;
  logic [XOR_KEYS-1:1]   lane_hit;

  // Window end when this beat completes an aligned window
  assign win_end = scan_i && (fill_q == XOR_FILL_W'(XOR_WINDOW - 1));

  // One counter per nonzero key
  for (genvar k = 1; k < XOR_KEYS; k++) begin : g_lane
    logic [XOR_CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
    logic                 pr;

    assign pr      = is_print(data_byte_i ^ 8'(k));
    assign cnt_inc = cnt_q + XOR_CNT_W'(pr);
    assign lane_hit[k] = win_end && (cnt_inc >= XOR_CNT_W'(xor_min_i));

    always_comb begin
      cnt_d = cnt_q;
      if (clear_i || win_end) begin
        cnt_d = '0;
      end else if (scan_i) begin
        cnt_d = cnt_inc;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
      end else if (beat_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  assign hit_d = hit_q | (|lane_hit);

  always_comb begin
    fill_d = fill_q;
    if (clear_i || win_end) begin
      fill_d = '0;
    end else if (scan_i) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else if (beat_i) begin
      fill_q <= fill_d;
      hit_q  <= clear_i ? 1'b0 : hit_d;
    end
  end

  assign xor_hit_o = hit_d;

endmodule

>>> rtl/core/ssc_seq_detect.sv
// Byte sequence detectors: NOP sled, GetPC, ROR-13 hash and stack strings.
// Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_seq_detect (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic                       clear_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [ssc_pkg::POS_W-1:0]  pos_i,
  input  logic [ssc_pkg::NOP_W-1:0]  nop_run_i,
  input  logic [ssc_pkg::PMIN_W-1:0] push_min_i,
  output ssc_pkg::seq_report_t       report_o
);
  import ssc_pkg::*;

  logic [7:0]            recent_q [5];
  logic [RUN_W-1:0]      run_q, run_d;
  hit_t                  sled_q, sled_d, call_q, call_d, fst_q, fst_d, ror_q, ror_d;
  logic [PUSH_SPAN-1:0]  marks_q, marks_d;
  logic [PUSH_CNT_W-1:0] pcnt_q, pcnt_d;
  logic                  stack_q, stack_d;
  logic [NOP_W-1:0]      need;
  logic                  is_nop, sled_c, call_c, fst_c, ror_c, push_q_c, push_en;
  logic [7:0]            b;

  assign b = data_byte_i;

  // Sled run length, saturating
  assign is_nop = (b == OP_NOP);
  assign need   = (nop_run_i == '0) ? NOP_W'(1) : nop_run_i;
  always_comb begin
    run_d = '0;
    if (is_nop) begin
      run_d = (run_q == '1) ? run_q : run_q + 1'b1;
    end
  end
  assign sled_c = is_nop && (RUN_W'(run_d) >= RUN_W'(need));

  // GetPC and ROR-13 patterns over the last five bytes plus this one
  assign call_c = (recent_q[0] == OP_CALL) && (recent_q[1] == 8'h00) &&
                  (recent_q[2] == 8'h00) && (recent_q[3] == 8'h00) &&
                  (recent_q[4] == 8'h00) && ((b & POP_MASK) == OP_POP_BASE);
  assign fst_c  = (recent_q[0] == FST_B0) && (recent_q[1] == FST_B1) &&
                  (recent_q[2] == FST_B0) && (recent_q[3] == FST_B3) &&
                  (recent_q[4] == FST_B4) && (b == FST_B5);
  assign ror_c  = (recent_q[3] == ROR_B0) && (recent_q[4] == ROR_B1) && (b == ROR_B2);

  // First-hit capture
  always_comb begin
    sled_d = sled_q;
    call_d = call_q;
    fst_d  = fst_q;
    ror_d  = ror_q;
    if (!sled_q.hit && sled_c) begin
      sled_d = '{hit: 1'b1, off: pos_i - POS_W'(need) + POS_W'(1)};
    end
    if (!call_q.hit && call_c) begin
      call_d = '{hit: 1'b1, off: pos_i - POS_W'(5)};
    end
    if (!fst_q.hit && fst_c) begin
      fst_d = '{hit: 1'b1, off: pos_i - POS_W'(5)};
    end
    if (!ror_q.hit && ror_c) begin
      ror_d = '{hit: 1'b1, off: pos_i - POS_W'(2)};
    end
  end

  // Push marks: push at pos-4 qualifies once its four operand bytes are in
  assign push_en  = (pos_i >= POS_W'(4));
  assign push_q_c = (recent_q[1] == OP_PUSH) &&
                    ((recent_q[2] == 8'h00) || is_print(recent_q[2])) &&
                    ((recent_q[3] == 8'h00) || is_print(recent_q[3])) &&
                    ((recent_q[4] == 8'h00) || is_print(recent_q[4])) &&
                    ((b == 8'h00) || is_print(b));

  // Running count of set marks: add the new one, drop the one shifted out
  always_comb begin
    marks_d = marks_q;
    pcnt_d  = pcnt_q;
    if (push_en) begin
      marks_d = {marks_q[PUSH_SPAN-2:0], push_q_c};
      pcnt_d  = pcnt_q + PUSH_CNT_W'(push_q_c) - PUSH_CNT_W'(marks_q[PUSH_SPAN-1]);
    end
  end
  assign stack_d = stack_q | (PMIN_W'(pcnt_d) >= push_min_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        recent_q[i] <= '0;
      end
      run_q   <= '0;
      sled_q  <= '0;
      call_q  <= '0;
      fst_q   <= '0;
      ror_q   <= '0;
      marks_q <= '0;
      pcnt_q  <= '0;
      stack_q <= 1'b0;
    end else if (beat_i) begin
      if (clear_i) begin
        for (int i = 0; i < 5; i++) begin
          recent_q[i] <= '0;
        end
        run_q   <= '0;
        sled_q  <= '0;
        call_q  <= '0;
        fst_q   <= '0;
        ror_q   <= '0;
        marks_q <= '0;
        pcnt_q  <= '0;
        stack_q <= 1'b0;
      end else begin
        for (int i = 0; i < 4; i++) begin
          recent_q[i] <= recent_q[i+1];
        end
        recent_q[4] <= b;
        run_q   <= run_d;
        sled_q  <= sled_d;
        call_q  <= call_d;
        fst_q   <= fst_d;
        ror_q   <= ror_d;
        marks_q <= marks_d;
        pcnt_q  <= pcnt_d;
        stack_q <= stack_d;
      end
    end
  end

  // Report as it stands after this beat; call-pop wins over fstenv
  always_comb begin
    report_o.sled_found   = sled_d.hit;
    report_o.sled_offset  = sled_d.hit ? sled_d.off : '0;
    report_o.getpc_found  = call_d.hit | fst_d.hit;
    report_o.getpc_offset = call_d.hit ? call_d.off : (fst_d.hit ? fst_d.off : '0);
    report_o.ror_found    = ror_d.hit;
    report_o.ror_offset   = ror_d.hit ? ror_d.off : '0;
    report_o.stack_hit    = stack_d;
  end

endmodule
